[src/drv_pkg.sv]
// Shared widths and cell control bundle for the dense rank vector block.
package drv_pkg;

    // Fixed field widths of the data and result beats.
    localparam int VALUE_W = 32;
    localparam int RANK_W  = 4;
    localparam int INDEX_W = 3;

    // Per-cycle control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic load;      // shift a new value into the chain
        logic dup_pass;  // circulate tokens and mark repeated values
        logic cnt_pass;  // circulate tokens and count distinct smaller values
        logic emit;      // shift ranks toward the output end
    } t_cell_ctrl;

endpackage

[src/dense_rank_vector.sv]
// Top level of the dense rank vector block: sequencer and a ring of ranking cells.
//
// Usage: drive i_value and raise start while busy is low; each such edge
// takes one value beat, in index order. When the VECTOR_LENGTH-th value is
// taken, busy rises for three phases: one in which value tokens circle the
// cell ring and repeated values are marked, one in which the tokens circle
// again and each cell counts the distinct smaller values, and one of
// results. The results follow on consecutive cycles in index order, each
// marked by o_valid for one cycle, with o_last on the final one. The token
// ring makes two full turns before the output shift.
// The receiver cannot stall; every result beat is taken in its cycle.
// Reset returns the sequencer to loading with no values held; a partly
// loaded vector is dropped.
module dense_rank_vector #(
    parameter int VECTOR_LENGTH = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic signed [drv_pkg::VALUE_W-1:0]  i_value,
    output logic                                busy,
    output logic                                o_valid,
    output logic [drv_pkg::RANK_W-1:0]          o_rank,
    output logic [drv_pkg::INDEX_W-1:0]         o_index,
    output logic                                o_last
);

    localparam int IW = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;
    localparam int CW = $clog2(VECTOR_LENGTH + 1);

    drv_pkg::t_cell_ctrl                w_ctrl;
    logic signed [drv_pkg::VALUE_W-1:0] w_value     [VECTOR_LENGTH];
    logic signed [drv_pkg::VALUE_W-1:0] w_tok_value [VECTOR_LENGTH];
    logic [IW-1:0]                      w_tok_idx   [VECTOR_LENGTH];
    logic                               w_tok_dup   [VECTOR_LENGTH];
    logic [CW-1:0]                      w_rank      [VECTOR_LENGTH];

    // Sequencer.
    drv_ctrl #(
        .VECTOR_LENGTH (VECTOR_LENGTH)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_ctrl  (w_ctrl),
        .o_valid (o_valid),
        .o_index (o_index),
        .o_last  (o_last)
    );

    // Ring of cells: values and ranks move toward cell 0, tokens wrap around.
    for (genvar g = 0; g < VECTOR_LENGTH; g++) begin : g_cell
        localparam int NEXT = (g + 1) % VECTOR_LENGTH;

        logic signed [drv_pkg::VALUE_W-1:0] w_load_in;
        logic [CW-1:0]                      w_rank_in;

        if (g == VECTOR_LENGTH - 1) begin : g_tail
            assign w_load_in = i_value;
            assign w_rank_in = '0;
        end else begin : g_body
            assign w_load_in = w_value[NEXT];
            assign w_rank_in = w_rank[NEXT];
        end

        drv_cell #(
            .VECTOR_LENGTH (VECTOR_LENGTH),
            .CELL_INDEX    (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_load_value (w_load_in),
            .i_tok_value  (w_tok_value[NEXT]),
            .i_tok_idx    (w_tok_idx[NEXT]),
            .i_tok_dup    (w_tok_dup[NEXT]),
            .i_rank       (w_rank_in),
            .o_value      (w_value[g]),
            .o_tok_value  (w_tok_value[g]),
            .o_tok_idx    (w_tok_idx[g]),
            .o_tok_dup    (w_tok_dup[g]),
            .o_rank       (w_rank[g])
        );
    end

    // The head cell presents the rank of the current result beat.
    assign o_rank = drv_pkg::RANK_W'(w_rank[0]);

endmodule

[src/drv_cell.sv]
// One cell of the ranking chain: a stored value, a circulating token and a rank count.
module drv_cell #(
    parameter int VECTOR_LENGTH = 8,
    parameter int CELL_INDEX    = 0
) (
    input  logic                                      i_clk,
    input  drv_pkg::t_cell_ctrl                       i_ctrl,
    input  logic signed [drv_pkg::VALUE_W-1:0]        i_load_value,
    input  logic signed [drv_pkg::VALUE_W-1:0]        i_tok_value,
    input  logic [((VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1)-1:0] i_tok_idx,
    input  logic                                      i_tok_dup,
    input  logic [$clog2(VECTOR_LENGTH + 1)-1:0]      i_rank,
    output logic signed [drv_pkg::VALUE_W-1:0]        o_value,
    output logic signed [drv_pkg::VALUE_W-1:0]        o_tok_value,
    output logic [((VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1)-1:0] o_tok_idx,
    output logic                                      o_tok_dup,
    output logic [$clog2(VECTOR_LENGTH + 1)-1:0]      o_rank
);

    localparam int IW = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;
    localparam int CW = $clog2(VECTOR_LENGTH + 1);

    logic signed [drv_pkg::VALUE_W-1:0] r_value;
    logic signed [drv_pkg::VALUE_W-1:0] r_tok_value;
    logic [IW-1:0]                      r_tok_idx;
    logic                               r_tok_dup;
    logic [CW-1:0]                      r_cnt;
    logic                               w_later_equal;
    logic                               w_counts;

    // A token from a later index that equals this cell's value is a repeat.
    assign w_later_equal = (r_tok_idx > IW'(CELL_INDEX)) && (r_tok_value == r_value);
    // A token counts once per distinct value that is strictly smaller.
    assign w_counts      = !r_tok_dup && (r_tok_value < r_value);

    // Outgoing token; the repeat mark is only added during the marking pass.
    assign o_value     = r_value;
    assign o_tok_value = r_tok_value;
    assign o_tok_idx   = r_tok_idx;
    assign o_tok_dup   = r_tok_dup | (i_ctrl.dup_pass & w_later_equal);
    assign o_rank      = r_cnt;

    // Load shifts values in; passes rotate tokens; emit shifts ranks out.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_value     <= i_load_value;
            r_tok_value <= i_load_value;
            r_tok_idx   <= IW'(CELL_INDEX);
            r_tok_dup   <= 1'b0;
            r_cnt       <= CW'(1);
        end else if (i_ctrl.dup_pass) begin
            r_tok_value <= i_tok_value;
            r_tok_idx   <= i_tok_idx;
            r_tok_dup   <= i_tok_dup;
        end else if (i_ctrl.cnt_pass) begin
            r_tok_value <= i_tok_value;
            r_tok_idx   <= i_tok_idx;
            r_tok_dup   <= i_tok_dup;
            if (w_counts) begin
                r_cnt <= r_cnt + CW'(1);
            end
        end else if (i_ctrl.emit) begin
            r_cnt <= i_rank;
        end
    end

endmodule

[src/drv_ctrl.sv]
// Sequencer for loading, the two token passes and the result burst.
module drv_ctrl #(
    parameter int VECTOR_LENGTH = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    output drv_pkg::t_cell_ctrl           o_ctrl,
    output logic                          o_valid,
    output logic [drv_pkg::INDEX_W-1:0]   o_index,
    output logic                          o_last
);

    localparam int CW = $clog2(VECTOR_LENGTH + 1);

    typedef enum logic [1:0] {
        S_LOAD,
        S_DUP,
        S_CNT,
        S_EMIT
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_count;
    logic          w_at_end;
    logic          w_load;

    assign w_at_end = (r_count == CW'(VECTOR_LENGTH - 1));
    assign w_load   = i_start && (r_state == S_LOAD);

    // Decode the cell controls and the result strobe from the state.
    assign o_busy          = (r_state != S_LOAD);
    assign o_ctrl.load     = w_load;
    assign o_ctrl.dup_pass = (r_state == S_DUP);
    assign o_ctrl.cnt_pass = (r_state == S_CNT);
    assign o_ctrl.emit     = (r_state == S_EMIT);
    assign o_valid         = (r_state == S_EMIT);
    assign o_index         = drv_pkg::INDEX_W'(r_count);
    assign o_last          = (r_state == S_EMIT) && w_at_end;

    // The counter tracks loaded values, then the cycles of each phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (w_load) begin
                        if (w_at_end) begin
                            r_state <= S_DUP;
                            r_count <= '0;
                        end else begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                end
                S_DUP: begin
                    if (w_at_end) begin
                        r_state <= S_CNT;
                        r_count <= '0;
                    end else begin
                        r_count <= r_count + CW'(1);
                    end
                end
                S_CNT: begin
                    if (w_at_end) begin
                        r_state <= S_EMIT;
                        r_count <= '0;
                    end else begin
                        r_count <= r_count + CW'(1);
                    end
                end
                S_EMIT: begin
                    if (w_at_end) begin
                        r_state <= S_LOAD;
                        r_count <= '0;
                    end else begin
                        r_count <= r_count + CW'(1);
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                    r_count <= '0;
                end
            endcase
        end
    end

endmodule

[bench/dense_rank_vector_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for dense_rank_vector: directed and random value vectors, dense rank prediction.
module dense_rank_vector_tb;

    localparam int VEC_LEN = 8;
    localparam int DIRECTED_VECTORS = 3;
    localparam int RANDOM_VECTORS = 50;

    // Value styles of the random vectors.
    localparam int unsigned STYLE_FULL_RANGE = 0;
    localparam int unsigned STYLE_SMALL_TIES = 1;
    localparam int unsigned STYLE_EXTREMES   = 2;
    localparam int unsigned STYLE_FEW_BASES  = 3;

    // One value beat and the idle time the driver leaves after it.
    typedef struct {
        logic signed [drv_pkg::VALUE_W-1:0] value;
        int unsigned gap_after;
    } t_value_beat;

    // One predicted result beat.
    typedef struct packed {
        logic [drv_pkg::RANK_W-1:0]  rank;
        logic [drv_pkg::INDEX_W-1:0] index;
        logic                        is_last;
    } t_rank_result;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                start;
    logic signed [drv_pkg::VALUE_W-1:0]  i_value;
    logic                                busy;
    logic                                o_valid;
    logic [drv_pkg::RANK_W-1:0]          o_rank;
    logic [drv_pkg::INDEX_W-1:0]         o_index;
    logic                                o_last;

    t_value_beat  pending_beats[$];
    t_rank_result expected_ranks[$];

    // Bench copy of the loaded vector.
    logic signed [drv_pkg::VALUE_W-1:0] held_values[VEC_LEN];
    int unsigned held_count;

    int unsigned gap_left;
    logic        beat_taken;
    t_value_beat next_beat;
    int unsigned fail_count;
    int unsigned results_checked;
    int unsigned vectors_ranked;

    dense_rank_vector #(
        .VECTOR_LENGTH(VEC_LEN)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_value (i_value),
        .busy    (busy),
        .o_valid (o_valid),
        .o_rank  (o_rank),
        .o_index (o_index),
        .o_last  (o_last)
    );

    // 50 MHz clock.
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Stores one accepted value; a full vector is ranked and its results queued.
    task automatic take_value(input logic signed [drv_pkg::VALUE_W-1:0] value);
        int unsigned smaller;
        bit seen_earlier;
        t_rank_result res;
        held_values[held_count] = value;
        held_count++;
        if (held_count == VEC_LEN) begin
            held_count = 0;
            vectors_ranked++;
            for (int a = 0; a < VEC_LEN; a++) begin
                smaller = 0;
                for (int b = 0; b < VEC_LEN; b++) begin
                    // Count each distinct smaller value at its first occurrence only.
                    if (held_values[b] < held_values[a]) begin
                        seen_earlier = 1'b0;
                        for (int c = 0; c < b; c++) begin
                            if (held_values[c] == held_values[b]) begin
                                seen_earlier = 1'b1;
                            end
                        end
                        if (!seen_earlier) begin
                            smaller++;
                        end
                    end
                end
                res.rank    = drv_pkg::RANK_W'(smaller + 1);
                res.index   = drv_pkg::INDEX_W'(a);
                res.is_last = (a == VEC_LEN - 1);
                expected_ranks.push_back(res);
            end
        end
    endtask

    // Idle time after a beat: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic queue_vector(input logic signed [drv_pkg::VALUE_W-1:0] vals[VEC_LEN],
                                input bit no_gaps);
        t_value_beat b;
        for (int k = 0; k < VEC_LEN; k++) begin
            b.value     = vals[k];
            b.gap_after = no_gaps ? 0 : pick_gap();
            pending_beats.push_back(b);
        end
    endtask

    // Driver: presents value beats at the falling edge.
    always @(negedge i_clk) begin
        if (i_rst_n && !(start && !beat_taken)) begin
            if (gap_left > 0) begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_beats.size() > 0) begin
                next_beat = pending_beats.pop_front();
                i_value  <= next_beat.value;
                start    <= 1'b1;
                gap_left <= next_beat.gap_after;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: takes accepted value beats and checks result beats at the rising edge.
    always @(posedge i_clk) begin
        t_rank_result want;
        if (!i_rst_n) begin
            beat_taken <= 1'b0;
        end else begin
            beat_taken <= start && !busy;
            if (o_valid) begin
                if (expected_ranks.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, %s %0d index %0d last %0b",
                             $time, "actual rank", o_rank, o_index, o_last);
                end else begin
                    want = expected_ranks.pop_front();
                    results_checked++;
                    if (o_rank !== want.rank) begin
                        fail_count++;
                        $display("%0t: rank mismatch at index %0d, expected %0d, actual %0d",
                                 $time, want.index, want.rank, o_rank);
                    end
                    if (o_index !== want.index) begin
                        fail_count++;
                        $display("%0t: index mismatch, expected %0d, actual %0d",
                                 $time, want.index, o_index);
                    end
                    if (o_last !== want.is_last) begin
                        fail_count++;
                        $display("%0t: last flag mismatch at index %0d, expected %0b, actual %0b",
                                 $time, want.index, want.is_last, o_last);
                    end
                end
            end
            if (start && !busy) begin
                take_value(i_value);
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        logic signed [drv_pkg::VALUE_W-1:0] vals[VEC_LEN];
        logic signed [drv_pkg::VALUE_W-1:0] extremes[7];
        logic signed [drv_pkg::VALUE_W-1:0] bases[3];
        int unsigned kind;

        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_value         = '0;
        gap_left        = 0;
        held_count      = 0;
        fail_count      = 0;
        results_checked = 0;
        vectors_ranked  = 0;

        extremes = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, -32'sd1, 32'sd1,
                     32'sh8000_0001, 32'sh7FFF_FFFE};

        // Directed: all values equal, so every rank is 1.
        foreach (vals[k]) vals[k] = 32'sh8000_0000;
        queue_vector(vals, 1'b1);
        // Directed: strictly descending through both extremes, ranks 8 down to 1.
        vals = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFE, 32'sd1, 32'sd0, -32'sd1,
                 -32'sd2, 32'sh8000_0001, 32'sh8000_0000};
        queue_vector(vals, 1'b0);
        // Directed: ties mixed with extremes, sign boundary around zero.
        vals = '{32'sd0, 32'sh7FFF_FFFF, -32'sd1, 32'sd0, 32'sh8000_0000,
                 32'sh7FFF_FFFF, -32'sd1, 32'sh8000_0000};
        queue_vector(vals, 1'b0);

        // Random vectors of several value styles.
        for (int v = 0; v < RANDOM_VECTORS; v++) begin
            kind = $urandom_range(STYLE_FULL_RANGE, STYLE_FEW_BASES);
            foreach (bases[j]) bases[j] = $urandom();
            for (int k = 0; k < VEC_LEN; k++) begin
                case (kind)
                    STYLE_FULL_RANGE: vals[k] = $urandom();
                    STYLE_SMALL_TIES: vals[k] = $signed($urandom_range(0, 5)) - 3;
                    STYLE_EXTREMES:   vals[k] = extremes[$urandom_range(0, 6)];
                    default:          vals[k] = bases[$urandom_range(0, 2)];
                endcase
            end
            queue_vector(vals, $urandom_range(0, 3) == 0);
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Drain: all beats sent, all results seen, then a last quiet stretch.
        while (pending_beats.size() != 0 || start) @(posedge i_clk);
        while (expected_ranks.size() != 0) @(posedge i_clk);
        repeat (4 * VEC_LEN + 8) @(posedge i_clk);

        $display("Ranked %0d vectors (%0d directed), %0d result beats checked.",
                 vectors_ranked, DIRECTED_VECTORS, results_checked);
        $display("Values covered full-range random, heavy ties and signed extremes.");
        if (fail_count == 0 && expected_ranks.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #5ms;
        $display("Timeout: %0d results still expected.", expected_ranks.size());
        $display("status: fail");
        $finish;
    end

endmodule
